// ===== rtl/core/isort_pkg.sv =====
`timescale 1ns / 1ps
// Shared types for the insertion sorter: controller states and the command
// and status groups that join the controller and the datapath. No dependencies.
package isort_pkg;

	// Controller states.
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_ALIGN,
		ST_EMIT
	} isort_state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic insert;    // insert the input value into the store
		logic load_run;  // the run ends: latch direction and alignment count
		logic shift_up;  // move every entry one place toward the top
		logic shift_dn;  // move every entry one place toward entry 0
		logic pad_dec;   // count down one alignment step
		logic emit;      // present one result and count the store down
	} isort_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic desc_cfg;  // live direction register
		logic desc_run;  // direction latched for the run being emitted
		logic pad_zero;  // alignment finished
		logic rem_last;  // one stored value left to emit
	} isort_status_t;

endpackage

// ===== rtl/core/isort_ctrl.sv =====
`timescale 1ns / 1ps
// Controller state machine of the insertion sorter.
// Depends on isort_pkg for the state, command and status types.
module isort_ctrl import isort_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic          last,
	input  isort_status_t status,
	output isort_cmd_t    cmd,
	output logic          busy
);

	isort_state_t state_q;
	isort_state_t state_d;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and commands.
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		busy    = 1'b1;
		case (state_q)
			ST_IDLE: begin
				busy = 1'b0;
				if (start) begin
					cmd.insert = 1'b1;
					if (last) begin
						cmd.load_run = 1'b1;
						state_d      = status.desc_cfg ? ST_ALIGN : ST_EMIT;
					end
				end
			end
			ST_ALIGN: begin
				// Push the largest value up to the top entry before a descending run.
				if (status.pad_zero) begin
					state_d = ST_EMIT;
				end else begin
					cmd.shift_up = 1'b1;
					cmd.pad_dec  = 1'b1;
				end
			end
			ST_EMIT: begin
				cmd.emit = 1'b1;
				if (status.desc_run) begin
					cmd.shift_up = 1'b1;
				end else begin
					cmd.shift_dn = 1'b1;
				end
				if (status.rem_last) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

// ===== rtl/core/isort_dp.sv =====
`timescale 1ns / 1ps
// Datapath of the insertion sorter: the compare-and-shift store, the run
// counters and the direction register. Depends on isort_pkg for command and status.
module isort_dp import isort_pkg::*; #(
	parameter int DEPTH = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  isort_cmd_t         cmd,
	input  logic signed [31:0] value,
	input  logic               cfg_we,
	input  logic               cfg_wdata,
	output isort_status_t      status,
	output logic signed [31:0] value_res,
	output logic               last_res,
	output logic               overflow
);

	localparam int CW = $clog2(DEPTH + 1);

	logic signed [31:0] store_q [DEPTH];
	logic [DEPTH-1:0]   gt;
	logic [CW-1:0]      count_q;
	logic [CW-1:0]      pad_q;
	logic [CW-1:0]      count_new;
	logic               full;
	logic               dropped_q;
	logic               descending_q;
	logic               desc_q;

	assign full      = (count_q == CW'(DEPTH));
	assign count_new = full ? count_q : count_q + CW'(1);

	// Each stored entry compares itself with the incoming value in parallel.
	always_comb begin
		for (int i = 0; i < DEPTH; i++) begin
			gt[i] = (CW'(i) < count_q) && (store_q[i] > value);
		end
	end

	// Store entries: insert, shift up or shift down.
	for (genvar i = 0; i < DEPTH; i++) begin : g_entry
		always_ff @(posedge clk) begin
			if (cmd.insert && !full) begin
				if (i > 0 && gt[(i > 0) ? i - 1 : 0]) begin
					store_q[i] <= store_q[(i > 0) ? i - 1 : 0];
				end else if (gt[i] || CW'(i) == count_q) begin
					store_q[i] <= value;
				end
			end else if (cmd.shift_up) begin
				if (i > 0) begin
					store_q[i] <= store_q[(i > 0) ? i - 1 : 0];
				end
			end else if (cmd.shift_dn) begin
				if (i < DEPTH - 1) begin
					store_q[i] <= store_q[(i < DEPTH - 1) ? i + 1 : i];
				end
			end
		end
	end

	// Run bookkeeping: fill count, drop flag, alignment count and run direction.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			dropped_q <= 1'b0;
			pad_q     <= '0;
			desc_q    <= 1'b0;
		end else begin
			if (cmd.insert) begin
				count_q <= count_new;
				if (full) begin
					dropped_q <= 1'b1;
				end
			end else if (cmd.emit) begin
				count_q <= count_q - CW'(1);
				if (count_q == CW'(1)) begin
					dropped_q <= 1'b0;
				end
			end
			if (cmd.load_run) begin
				pad_q  <= CW'(DEPTH) - count_new;
				desc_q <= descending_q;
			end else if (cmd.pad_dec) begin
				pad_q <= pad_q - CW'(1);
			end
		end
	end

	// Direction register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			descending_q <= 1'b0;
		end else if (cfg_we) begin
			descending_q <= cfg_wdata;
		end
	end

	// Status and result fields.
	assign status.desc_cfg = descending_q;
	assign status.desc_run = desc_q;
	assign status.pad_zero = (pad_q == '0);
	assign status.rem_last = (count_q == CW'(1));

	assign value_res = desc_q ? store_q[DEPTH-1] : store_q[0];
	assign last_res  = (count_q == CW'(1));
	assign overflow  = dropped_q;

endmodule

// ===== rtl/core/insertion_sorter.sv =====
`timescale 1ns / 1ps
// Insertion sorter. An item without last is inserted at once; busy stays low.
// After the item with last, n results follow on consecutive cycles starting the next
// cycle (ascending), or after the store has been shifted into alignment (descending).
// The results of a run go out back to back; the receiver cannot stall them.
// Reset clears the count, drop flag, direction and controller; store contents are not reset.
module insertion_sorter import isort_pkg::*; #(
	parameter int DEPTH = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic signed [31:0] value,
	input  logic               last,
	input  logic               cfg_we,
	input  logic               cfg_wdata,
	output logic               res_valid,
	output logic signed [31:0] value_res,
	output logic               last_res,
	output logic               overflow
);

	isort_cmd_t    cmd;
	isort_status_t status;

	// Controller.
	isort_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.last   (last),
		.status (status),
		.cmd    (cmd),
		.busy   (busy)
	);

	// Datapath.
	isort_dp #(
		.DEPTH (DEPTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.value     (value),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.status    (status),
		.value_res (value_res),
		.last_res  (last_res),
		.overflow  (overflow)
	);

	// A result is on the ports for each emit cycle.
	assign res_valid = cmd.emit;

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for insertion_sorter: a queue-fed driver, a result monitor
// and an in-bench sorting predictor, checked over directed and random runs.
// Depends only on the RTL of insertion_sorter.
module tb;

	localparam int SORT_DEPTH = 16;
	// Settling margin the bench waits after every result of the queued runs is out.
	localparam int DRAIN_CYCLES = 2 * SORT_DEPTH + 4;

	// One input item: a value and the end-of-run mark.
	typedef struct {
		logic signed [31:0] val;
		logic               mark;
	} sort_item_t;

	// One expected result of an emitted run.
	typedef struct {
		logic signed [31:0] val;
		logic               fin;
		logic               ovf;
	} sorted_result_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               start = 1'b0;
	logic               busy;
	logic signed [31:0] value = '0;
	logic               last = 1'b0;
	logic               cfg_we = 1'b0;
	logic               cfg_wdata = 1'b0;
	logic               res_valid;
	logic signed [31:0] value_res;
	logic               last_res;
	logic               overflow;

	// Predictor state: the sorted store, its fill level, the drop flag and direction.
	logic signed [31:0] run_store [SORT_DEPTH];
	int                 run_count = 0;
	logic               run_dropped = 1'b0;
	logic               order_desc = 1'b0;

	sort_item_t         pending_items [$];
	sorted_result_t     due_results [$];

	int  errors = 0;
	int  items_sent = 0;
	int  results_checked = 0;
	int  runs_emitted = 0;
	int  overflow_runs = 0;
	int  desc_runs = 0;
	int  gap_left = 0;
	bit  steady = 1'b0;

	insertion_sorter #(
		.DEPTH(SORT_DEPTH)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.value(value),
		.last(last),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.res_valid(res_valid),
		.value_res(value_res),
		.last_res(last_res),
		.overflow(overflow)
	);

	always #5 clk = ~clk;

	// Insert one accepted value; on a marked item, queue the whole run in output order.
	task automatic absorb_item(input logic signed [31:0] v, input logic mark);
		int pos;
		int src;
		sorted_result_t r;
		if (run_count >= SORT_DEPTH) begin
			run_dropped = 1'b1;
		end else begin
			pos = run_count;
			while (pos > 0 && run_store[pos - 1] > v) begin
				run_store[pos] = run_store[pos - 1];
				pos--;
			end
			run_store[pos] = v;
			run_count++;
		end
		if (mark) begin
			for (int k = 0; k < run_count; k++) begin
				src = order_desc ? (run_count - 1 - k) : k;
				r.val = run_store[src];
				r.fin = (k == run_count - 1);
				r.ovf = run_dropped;
				due_results.push_back(r);
			end
			runs_emitted++;
			if (run_dropped)
				overflow_runs++;
			if (order_desc)
				desc_runs++;
			run_count = 0;
			run_dropped = 1'b0;
		end
	endtask

	// Value mix: extremes, a narrow band that produces duplicates, and full-range noise.
	function automatic logic signed [31:0] pick_value();
		case ($urandom_range(0, 9))
			0: begin
				case ($urandom_range(0, 3))
					0: return 32'sh8000_0000;
					1: return 32'sh7fff_ffff;
					2: return 32'sh0000_0000;
					default: return 32'shffff_ffff;
				endcase
			end
			1, 2, 3: return $signed($urandom_range(0, 15)) - 8;
			default: return $signed($urandom);
		endcase
	endfunction

	task automatic queue_item(input logic signed [31:0] v, input logic mark);
		sort_item_t it;
		it.val = v;
		it.mark = mark;
		pending_items.push_back(it);
	endtask

	// Random runs, mostly within capacity, some short, a few that overflow the store.
	task automatic queue_random_runs(input int n_target);
		int total;
		int len;
		total = 0;
		while (total < n_target) begin
			case ($urandom_range(0, 9))
				0: len = $urandom_range(SORT_DEPTH + 1, SORT_DEPTH + 4);
				1: len = 1;
				default: len = $urandom_range(2, SORT_DEPTH);
			endcase
			for (int i = 0; i < len; i++)
				queue_item(pick_value(), i == len - 1);
			total += len;
		end
	endtask

	// Wait until every item is in and every result is out, then let the block settle.
	task automatic wait_drained();
		while (pending_items.size() != 0 || start || due_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_direction(input logic desc);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= desc;
		order_desc = desc;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// Driver: holds each item until accepted, with random idle bursts between items.
	always @(posedge clk) begin : drive
		logic               nxt_start;
		logic signed [31:0] nxt_val;
		logic               nxt_last;
		sort_item_t         it;
		if (arst_n) begin
			nxt_start = start;
			nxt_val = value;
			nxt_last = last;
			if (start && !busy) begin
				absorb_item(value, last);
				items_sent++;
				nxt_start = 1'b0;
			end
			if (!nxt_start) begin
				if (gap_left > 0) begin
					gap_left--;
				end else if (pending_items.size() != 0) begin
					if (!steady && $urandom_range(0, 4) == 0) begin
						gap_left = $urandom_range(0, 2);
					end else begin
						it = pending_items.pop_front();
						nxt_start = 1'b1;
						nxt_val = it.val;
						nxt_last = it.mark;
					end
				end
			end
			start <= nxt_start;
			value <= nxt_val;
			last <= nxt_last;
		end
	end

	// Monitor: every strobed result must match the oldest expected one.
	always @(posedge clk) begin : watch
		sorted_result_t exp_r;
		if (arst_n && res_valid) begin
			if (due_results.size() == 0) begin
				$display("%0t: unexpected result, expected none, got value %0d last %0b ovf %0b",
					$time, value_res, last_res, overflow);
				errors++;
			end else begin
				exp_r = due_results.pop_front();
				results_checked++;
				if (value_res !== exp_r.val) begin
					$display("%0t: value_res mismatch, expected %0d, got %0d",
						$time, exp_r.val, value_res);
					errors++;
				end
				if (last_res !== exp_r.fin) begin
					$display("%0t: last_res mismatch, expected %0b, got %0b",
						$time, exp_r.fin, last_res);
					errors++;
				end
				if (overflow !== exp_r.ovf) begin
					$display("%0t: overflow mismatch, expected %0b, got %0b",
						$time, exp_r.ovf, overflow);
					errors++;
				end
			end
		end
	end

	// Stimulus sequence: reset, directed runs, then random phases with both directions.
	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Directed runs in ascending order.
		write_direction(1'b0);
		queue_item(32'sh7fff_ffff, 1'b1);
		queue_item(32'sh7fff_ffff, 1'b0);
		queue_item(32'sh8000_0000, 1'b0);
		queue_item(32'sh0000_0000, 1'b0);
		queue_item(32'shffff_ffff, 1'b0);
		queue_item(32'sh0000_0001, 1'b0);
		queue_item(32'sh8000_0000, 1'b1);
		// A full store, then a dropped marked item.
		for (int i = 0; i < SORT_DEPTH + 1; i++)
			queue_item($signed(SORT_DEPTH - i) * 32'sh0101_0101, i == SORT_DEPTH);
		wait_drained();

		// Random phases, alternating direction; the last one runs without idling.
		for (int ph = 0; ph < 6; ph++) begin
			write_direction(ph[0] ? 1'b0 : 1'b1);
			if (ph == 5)
				steady = 1'b1;
			queue_random_runs(26);
			wait_drained();
		end

		$display("Checked %0d results from %0d runs over %0d items.",
			results_checked, runs_emitted, items_sent);
		$display("Runs emitted descending: %0d; runs with dropped values: %0d.",
			desc_runs, overflow_runs);
		if (errors == 0 && due_results.size() == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

	// Watchdog.
	initial begin
		#2_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule

// ===== files.f =====
rtl/core/isort_pkg.sv
rtl/core/isort_ctrl.sv
rtl/core/isort_dp.sv
rtl/core/insertion_sorter.sv
dv/tb.sv
